FILE: rtl/core/sct_pkg.sv
// ----------------------------------------------------------------------------
// sct_pkg
// Shared widths, operation kinds and queue record for the strip calibration
// block.
// ----------------------------------------------------------------------------
package sct_pkg;

    localparam int RAW_W    = 13;
    localparam int GAIN_W   = 16;
    localparam int OFFS_W   = 16;
    localparam int ENERGY_W = 22;
    localparam int CNT_W    = 6;
    localparam int SUM_W    = 27;
    localparam int DIFF_W   = 19;
    localparam int PROD_W   = DIFF_W + GAIN_W + 1;
    localparam int WORD_W   = ENERGY_W + OFFS_W + GAIN_W;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [GAIN_W-1:0]   GAIN_RESET = 16'd4096;
    localparam logic [OFFS_W-1:0]   OFFS_RESET = '0;
    localparam logic [ENERGY_W-1:0] THR_RESET  = '0;

    typedef enum logic [1:0] {
        OP_SAMPLE,
        OP_SKIP,
        OP_LOAD_ACK,
        OP_LOAD_NACK
    } op_kind_t;

    typedef struct packed {
        op_kind_t                   kind;
        logic                       last;
        logic signed [DIFF_W-1:0]   diff;
        logic [GAIN_W-1:0]          gain;
        logic signed [ENERGY_W-1:0] thr;
    } sct_op_t;

    typedef struct packed {
        logic    valid;
        sct_op_t op;
    } sct_push_t;

endpackage

FILE: rtl/core/sct_if.sv
// ----------------------------------------------------------------------------
// sct_if
// Request and response channels: valid/ready handshake plus payload.
// ----------------------------------------------------------------------------
interface sct_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic        detector;
    logic        side;
    logic [4:0]  strip;
    logic [12:0] raw_value;
    logic        last_in_group;
    logic [15:0] gain_value;
    logic signed [15:0] offset_value;
    logic signed [21:0] threshold_value;

    modport source (
        output valid, req_type, detector, side, strip, raw_value, last_in_group,
               gain_value, offset_value, threshold_value,
        input  ready
    );
    modport sink (
        input  valid, req_type, detector, side, strip, raw_value, last_in_group,
               gain_value, offset_value, threshold_value,
        output ready
    );
endinterface

interface sct_rsp_if;
    logic        valid;
    logic        ready;
    logic signed [21:0] strip_energy;
    logic        strip_hit;
    logic [5:0]  group_multiplicity;
    logic signed [26:0] group_sum;
    logic        group_done;
    logic        load_ack;

    modport source (
        output valid, strip_energy, strip_hit, group_multiplicity, group_sum,
               group_done, load_ack,
        input  ready
    );
    modport sink (
        input  valid, strip_energy, strip_hit, group_multiplicity, group_sum,
               group_done, load_ack,
        output ready
    );
endinterface

FILE: rtl/core/sct_ram.sv
// ----------------------------------------------------------------------------
// sct_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module sct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/sct_front.sv
// ----------------------------------------------------------------------------
// sct_front
// Accepts transactions, decodes strip address, owns the calibration RAM and
// its init sweep, and pushes classified operations into the queue.
// ----------------------------------------------------------------------------
module sct_front #(
    parameter int NUM_DETECTORS   = 2,
    parameter int STRIPS_PER_SIDE = 32,
    parameter int ADC_BITS        = 13
) (
    input  logic                 clk,
    input  logic                 rst_n,
    sct_req_if.sink              req,
    input  logic                 q_full,
    output sct_pkg::sct_push_t   push
);
    import sct_pkg::*;

    localparam int DEPTH   = NUM_DETECTORS * 2 * STRIPS_PER_SIDE;
    localparam int AW      = $clog2(DEPTH);
    localparam int RAW_USE = (ADC_BITS < RAW_W) ? ADC_BITS : RAW_W;
    localparam logic [RAW_W-1:0] RAW_MASK = RAW_W'((32'd1 << RAW_USE) - 32'd1);

    logic          init_busy_reg;
    logic [AW-1:0] init_cnt_reg;

    logic          f1_valid_reg;
    op_kind_t      f1_kind_reg;
    logic          f1_last_reg;
    logic [RAW_W-1:0] f1_raw_reg;

    logic          accept;
    logic          addr_ok;
    logic [31:0]   idx_full;
    logic [AW-1:0] addr;
    op_kind_t      kind_next;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [WORD_W-1:0] ram_rdata;

    logic signed [DIFF_W-1:0] raw_q4;
    logic signed [DIFF_W-1:0] offs_ext;

    assign req.ready = !init_busy_reg && (!f1_valid_reg || !q_full);
    assign accept    = req.valid && req.ready;

    assign addr_ok  = (32'(req.detector) < NUM_DETECTORS)
                   && (32'(req.strip) < STRIPS_PER_SIDE);
    assign idx_full = (32'(req.detector) * 32'd2 + 32'(req.side)) * STRIPS_PER_SIDE
                    + 32'(req.strip);
    assign addr     = idx_full[AW-1:0];

    always_comb
    begin
        if (req.req_type)
        begin
            kind_next = addr_ok ? OP_LOAD_ACK : OP_LOAD_NACK;
        end
        else
        begin
            kind_next = addr_ok ? OP_SAMPLE : OP_SKIP;
        end
    end

    // init sweep writes reset values, one entry a cycle
    always_comb
    begin
        if (init_busy_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = init_cnt_reg;
            ram_wdata = {THR_RESET, OFFS_RESET, GAIN_RESET};
        end
        else
        begin
            ram_we    = accept && req.req_type && addr_ok;
            ram_waddr = addr;
            ram_wdata = {req.threshold_value, req.offset_value, req.gain_value};
        end
    end

    sct_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_cal_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept && !req.req_type),
        .raddr (addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_busy_reg <= 1'b1;
            init_cnt_reg  <= '0;
            f1_valid_reg  <= 1'b0;
        end
        else
        begin
            if (init_busy_reg)
            begin
                if (init_cnt_reg == AW'(DEPTH - 1))
                begin
                    init_busy_reg <= 1'b0;
                end
                else
                begin
                    init_cnt_reg <= init_cnt_reg + 1'b1;
                end
            end
            if (accept)
            begin
                f1_valid_reg <= 1'b1;
            end
            else if (push.valid)
            begin
                f1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f1_kind_reg <= kind_next;
            f1_last_reg <= req.last_in_group;
            f1_raw_reg  <= req.raw_value & RAW_MASK;
        end
    end

    assign raw_q4   = DIFF_W'({f1_raw_reg, 4'b0000});
    assign offs_ext = DIFF_W'($signed(ram_rdata[GAIN_W +: OFFS_W]));

    always_comb
    begin
        push.valid   = f1_valid_reg && !q_full;
        push.op.kind = f1_kind_reg;
        push.op.last = f1_last_reg;
        push.op.diff = raw_q4 - offs_ext;
        push.op.gain = ram_rdata[GAIN_W-1:0];
        push.op.thr  = $signed(ram_rdata[GAIN_W+OFFS_W +: ENERGY_W]);
    end

endmodule

FILE: rtl/core/sct_queue.sv
// ----------------------------------------------------------------------------
// sct_queue
// Short FIFO of classified operations between front and back.
// ----------------------------------------------------------------------------
module sct_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  sct_pkg::sct_push_t  push,
    output logic                full,
    input  logic                pop,
    output logic                empty,
    output sct_pkg::sct_op_t    head
);
    import sct_pkg::*;

    sct_op_t             slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wptr_reg;
    logic [QPTR_W-1:0]   rptr_reg;
    logic [QPTR_W:0]     count_reg;

    assign full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push.valid)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            if (push.valid && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push.valid)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            slot_reg[wptr_reg] <= push.op;
        end
    end

endmodule

FILE: rtl/core/sct_back.sv
// ----------------------------------------------------------------------------
// sct_back
// Gain multiply, rounding and saturation, threshold compare, group totals
// and the response register.
// ----------------------------------------------------------------------------
module sct_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  sct_pkg::sct_op_t  q_head,
    output logic              q_pop,
    sct_rsp_if.source         rsp
);
    import sct_pkg::*;

    localparam logic signed [PROD_W:0]  E_HI = 2097151;
    localparam logic signed [PROD_W:0]  E_LO = -2097152;
    localparam logic signed [SUM_W:0]   S_HI = 67108863;
    localparam logic signed [SUM_W:0]   S_LO = -67108864;
    localparam logic [CNT_W-1:0]        CNT_MAX = '1;

    // multiply stage
    logic                       b1_valid_reg;
    op_kind_t                   b1_kind_reg;
    logic                       b1_last_reg;
    logic signed [PROD_W-1:0]   b1_prod_reg;
    logic signed [ENERGY_W-1:0] b1_thr_reg;

    // round / compare stage
    logic                       b2_valid_reg;
    op_kind_t                   b2_kind_reg;
    logic                       b2_last_reg;
    logic signed [ENERGY_W-1:0] b2_energy_reg;
    logic                       b2_hit_reg;

    // response register
    logic                       out_valid_reg;
    logic signed [ENERGY_W-1:0] out_energy_reg;
    logic                       out_hit_reg;
    logic [CNT_W-1:0]           out_mult_reg;
    logic signed [SUM_W-1:0]    out_sum_reg;
    logic                       out_done_reg;
    logic                       out_ack_reg;

    logic [CNT_W-1:0]           cnt_reg;
    logic signed [SUM_W-1:0]    sum_reg;

    logic                       out_load;
    logic                       b2_en;
    logic                       b1_en;

    logic signed [PROD_W-1:0]   prod_next;
    logic signed [PROD_W:0]     rnd;
    logic signed [PROD_W:0]     shifted;
    logic signed [ENERGY_W-1:0] energy_next;
    logic                       hit_next;
    logic signed [SUM_W:0]      sum_wide;
    logic [CNT_W-1:0]           cnt_next;
    logic signed [SUM_W-1:0]    sum_next;
    logic                       is_load;

    assign out_load = b2_valid_reg && (!out_valid_reg || rsp.ready);
    assign b2_en    = !b2_valid_reg || out_load;
    assign b1_en    = !b1_valid_reg || b2_en;
    assign q_pop    = !q_empty && b1_en;

    assign prod_next = PROD_W'(q_head.diff) * PROD_W'($signed({1'b0, q_head.gain}));

    // floor((p + 2048) / 4096) then clamp
    always_comb
    begin
        rnd     = (PROD_W+1)'(b1_prod_reg) + (PROD_W+1)'(2048);
        shifted = rnd >>> 12;
        if (b1_kind_reg != OP_SAMPLE)
        begin
            energy_next = '0;
        end
        else if (shifted > E_HI)
        begin
            energy_next = E_HI[ENERGY_W-1:0];
        end
        else if (shifted < E_LO)
        begin
            energy_next = E_LO[ENERGY_W-1:0];
        end
        else
        begin
            energy_next = shifted[ENERGY_W-1:0];
        end
        hit_next = (b1_kind_reg == OP_SAMPLE) && (energy_next > b1_thr_reg);
    end

    always_comb
    begin
        sum_wide = (SUM_W+1)'(sum_reg) + (SUM_W+1)'(b2_energy_reg);
        cnt_next = cnt_reg;
        sum_next = sum_reg;
        if (b2_hit_reg)
        begin
            if (cnt_reg != CNT_MAX)
            begin
                cnt_next = cnt_reg + 1'b1;
            end
            if (sum_wide > S_HI)
            begin
                sum_next = S_HI[SUM_W-1:0];
            end
            else if (sum_wide < S_LO)
            begin
                sum_next = S_LO[SUM_W-1:0];
            end
            else
            begin
                sum_next = sum_wide[SUM_W-1:0];
            end
        end
        is_load = (b2_kind_reg == OP_LOAD_ACK) || (b2_kind_reg == OP_LOAD_NACK);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg  <= 1'b0;
            b2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            sum_reg       <= '0;
        end
        else
        begin
            if (b1_en)
            begin
                b1_valid_reg <= q_pop;
            end
            if (b2_en)
            begin
                b2_valid_reg <= b1_valid_reg;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (out_load && !is_load)
            begin
                if (b2_last_reg)
                begin
                    cnt_reg <= '0;
                    sum_reg <= '0;
                end
                else
                begin
                    cnt_reg <= cnt_next;
                    sum_reg <= sum_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            b1_kind_reg <= q_head.kind;
            b1_last_reg <= q_head.last;
            b1_prod_reg <= prod_next;
            b1_thr_reg  <= q_head.thr;
        end
        if (b2_en && b1_valid_reg)
        begin
            b2_kind_reg   <= b1_kind_reg;
            b2_last_reg   <= b1_last_reg;
            b2_energy_reg <= energy_next;
            b2_hit_reg    <= hit_next;
        end
        if (out_load)
        begin
            if (is_load)
            begin
                out_energy_reg <= '0;
                out_hit_reg    <= 1'b0;
                out_mult_reg   <= '0;
                out_sum_reg    <= '0;
                out_done_reg   <= 1'b0;
                out_ack_reg    <= (b2_kind_reg == OP_LOAD_ACK);
            end
            else
            begin
                out_energy_reg <= b2_energy_reg;
                out_hit_reg    <= b2_hit_reg;
                out_mult_reg   <= cnt_next;
                out_sum_reg    <= sum_next;
                out_done_reg   <= b2_last_reg;
                out_ack_reg    <= 1'b0;
            end
        end
    end

    assign rsp.valid              = out_valid_reg;
    assign rsp.strip_energy       = out_energy_reg;
    assign rsp.strip_hit          = out_hit_reg;
    assign rsp.group_multiplicity = out_mult_reg;
    assign rsp.group_sum          = out_sum_reg;
    assign rsp.group_done         = out_done_reg;
    assign rsp.load_ack           = out_ack_reg;

endmodule

FILE: rtl/core/strip_calibrate_threshold_sum.sv
// ----------------------------------------------------------------------------
// strip_calibrate_threshold_sum
// Per-strip gain/offset calibration with threshold and group hit totals.
// ----------------------------------------------------------------------------
// One transaction per clock in and one result per clock out, sustained while
// the output is not stalled. A transaction either loads one calibration entry
// (gain, offset, threshold) or calibrates one raw sample; every transaction
// returns exactly one result. The rate is set by the single-port read of the
// calibration RAM in the front and the multiply, round/compare and accumulate
// stages in the back; a four-entry queue between them absorbs output stalls.
// After reset the calibration RAM is swept to unity gain, zero offset and zero
// threshold, all NUM_DETECTORS*2*STRIPS_PER_SIDE entries (128 by default),
// with ready low.
// ----------------------------------------------------------------------------
module strip_calibrate_threshold_sum #(
    parameter int NUM_DETECTORS   = 2,
    parameter int STRIPS_PER_SIDE = 32,
    parameter int ADC_BITS        = 13
) (
    input  logic       clk,
    input  logic       rst_n,
    sct_req_if.sink    req,
    sct_rsp_if.source  rsp
);
    import sct_pkg::*;

    sct_push_t push;
    logic      q_full;
    logic      q_empty;
    logic      q_pop;
    sct_op_t   q_head;

    sct_front #(
        .NUM_DETECTORS   (NUM_DETECTORS),
        .STRIPS_PER_SIDE (STRIPS_PER_SIDE),
        .ADC_BITS        (ADC_BITS)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .q_full (q_full),
        .push   (push)
    );

    sct_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (q_full),
        .pop   (q_pop),
        .empty (q_empty),
        .head  (q_head)
    );

    sct_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .rsp     (rsp)
    );

endmodule
